// ===== src/drrip_dead_block_replacement_assert.svh =====
// Assertion macros for the DRRIP dead-block replacement block.
// Expects clk and arst_n in the scope of each use.
`ifndef DRRIP_DEAD_BLOCK_REPLACEMENT_ASSERT_SVH
`define DRRIP_DEAD_BLOCK_REPLACEMENT_ASSERT_SVH

// Consequent holds in the same cycle.
`define DRRIP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drrip assertion failed");

// Consequent holds in the next cycle.
`define DRRIP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drrip assertion failed");

`endif

// ===== src/drrip_pkg.sv =====
// Shared constants, types and helpers of the DRRIP dead-block replacement block.
// No dependencies.
`default_nettype none
package drrip_pkg;
	localparam int DEF_NUM_SETS    = 2048;
	localparam int DEF_NUM_WAYS    = 16;
	localparam int DEF_LEADER_SETS = 64;

	localparam logic [9:0]  PSEL_MID  = 10'd512;
	localparam logic [9:0]  PSEL_MAX  = 10'd1023;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam logic [1:0] RRPV_NEAR = 2'd0;
	localparam logic [1:0] RRPV_INS  = 2'd2;
	localparam logic [1:0] RRPV_MAX  = 2'd3;
	localparam logic [1:0] DEAD_FILL = 2'd1;
	localparam logic [1:0] DEAD_MAX  = 2'd3;

	localparam logic OP_VICTIM = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic op;
		logic hit;
		logic srrip;
		logic far_ins;
	} drrip_ctl_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] cur);
		logic [15:0] nxt;
		nxt = {1'b0, cur[15:1]};
		if (cur[0]) begin
			nxt = nxt ^ LFSR_TAPS;
		end
		return nxt;
	endfunction
endpackage
`default_nettype wire

// ===== src/drrip_if.sv =====
// Request and response channel interfaces of the DRRIP replacement block.
// Depends on nothing.
`default_nettype none
interface drrip_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [10:0] set_index;
	logic [15:0] valid_mask;
	logic [3:0]  way;
	logic        hit;
	modport source (output valid, op, set_index, valid_mask, way, hit, input ready);
	modport sink (input valid, op, set_index, valid_mask, way, hit, output ready);
endinterface

interface drrip_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] victim_way;
	modport source (output valid, victim_way, input ready);
	modport sink (input valid, victim_way, output ready);
endinterface
`default_nettype wire

// ===== src/drrip_row_mem.sv =====
// Set-row memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module drrip_row_mem #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/drrip_set_logic.sv =====
// Per-set victim search and update of one row of RRPV and dead counters.
// Depends on drrip_pkg.
`default_nettype none
module drrip_set_logic #(
	parameter int NUM_WAYS = 16
) (
	input  wire drrip_pkg::drrip_ctl_t          ctl,
	input  wire logic [15:0]                    valid_mask,
	input  wire logic [3:0]                     way,
	input  wire logic [NUM_WAYS-1:0][1:0]       rrpv,
	input  wire logic [NUM_WAYS-1:0][1:0]       dead,
	output logic      [NUM_WAYS-1:0][1:0]       rrpv_new,
	output logic      [NUM_WAYS-1:0][1:0]       dead_new,
	output logic      [3:0]                     victim
);
	import drrip_pkg::*;

	logic [31:0] vm_ext;
	logic [1:0]  top;
	logic [1:0]  lift;
	logic [NUM_WAYS-1:0][1:0] aged;
	logic        found;

	assign vm_ext = {16'd0, valid_mask};

	always_comb begin
		top = 2'd0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (rrpv[w] > top) begin
				top = rrpv[w];
			end
		end
		lift = RRPV_MAX - top;
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged[w] = rrpv[w] + lift;
		end
	end

	always_comb begin
		victim   = 4'd0;
		found    = 1'b0;
		rrpv_new = rrpv;
		dead_new = dead;
		if (ctl.op == OP_VICTIM) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (!found && !vm_ext[w]) begin
					found  = 1'b1;
					victim = 4'(w);
				end
			end
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (!found && dead[w] == DEAD_MAX) begin
					found  = 1'b1;
					victim = 4'(w);
				end
			end
			if (!found) begin
				rrpv_new = aged;
				for (int w = 0; w < NUM_WAYS; w++) begin
					if (!found && aged[w] == RRPV_MAX) begin
						found  = 1'b1;
						victim = 4'(w);
					end
				end
			end
		end else begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if ({1'b0, way} == 5'(w)) begin
					if (ctl.hit) begin
						rrpv_new[w] = RRPV_NEAR;
						dead_new[w] = (dead[w] != 2'd0) ? dead[w] - 2'd1 : 2'd0;
					end else begin
						rrpv_new[w] = (!ctl.srrip && ctl.far_ins) ? RRPV_MAX : RRPV_INS;
						dead_new[w] = DEAD_FILL;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/drrip_dead_block_replacement.sv =====
// Top level of the DRRIP replacement policy with dead-block counters.
// Depends on drrip_pkg, drrip_if, drrip_row_mem, drrip_set_logic.
//
// channel | dir | payload
// req     | in  | op, set_index, valid_mask, way, hit
// rsp     | out | victim_way (victim op only)
//
// Each transaction reads its row from the set memory, then computes and
// writes it back. After reset a fill pass writes every row with
// req.ready low. Every NUM_SETS*NUM_WAYS updates a decay pass decrements
// every dead counter. A stalled response holds the next victim op.
`default_nettype none
module drrip_dead_block_replacement #(
	parameter int NUM_SETS    = drrip_pkg::DEF_NUM_SETS,
	parameter int NUM_WAYS    = drrip_pkg::DEF_NUM_WAYS,
	parameter int LEADER_SETS = drrip_pkg::DEF_LEADER_SETS
) (
	input wire logic clk,
	input wire logic arst_n,
	drrip_req_if.sink   req,
	drrip_rsp_if.source rsp
);
	import drrip_pkg::*;

	localparam int SW     = $clog2(NUM_SETS);
	localparam int BLOCKS = NUM_SETS * NUM_WAYS;
	localparam int CW     = $clog2(BLOCKS);
	localparam int RW     = 4 * NUM_WAYS;
	localparam logic [SW:0] LEAD_HALF = (SW+1)'(LEADER_SETS / 2);
	localparam logic [SW:0] LEAD_ALL  = (SW+1)'(LEADER_SETS);

	typedef enum logic [4:0] {
		ST_CLEAR    = 5'b00001,
		ST_IDLE     = 5'b00010,
		ST_EXEC     = 5'b00100,
		ST_DECAY_RD = 5'b01000,
		ST_DECAY_WR = 5'b10000
	} state_t;

	state_t state_q;
	logic [SW-1:0] sweep_q;
	logic [CW-1:0] cnt_q;
	logic [9:0]    psel_q;
	logic [15:0]   lfsr_q;
	logic          out_valid_q;
	logic [3:0]    victim_q;

	logic          op_q;
	logic [SW-1:0] set_q;
	logic [15:0]   vmask_q;
	logic [3:0]    way_q;
	logic          hit_q;

	logic [SW-1:0] req_set;
	logic          accept;
	logic          stall;
	logic          leave;
	logic          upd;
	logic          srrip_lead;
	logic          brrip_lead;
	logic          wrap;
	logic [15:0]   lfsr_nx;
	drrip_ctl_t    ctl;

	logic          we;
	logic [SW-1:0] waddr;
	logic [RW-1:0] wdata;
	logic [SW-1:0] raddr;
	logic [RW-1:0] rdata;

	logic [NUM_WAYS-1:0][1:0] rrpv_rd;
	logic [NUM_WAYS-1:0][1:0] dead_rd;
	logic [NUM_WAYS-1:0][1:0] rrpv_new;
	logic [NUM_WAYS-1:0][1:0] dead_new;
	logic [NUM_WAYS-1:0][1:0] dead_dec;
	logic [3:0]               victim;

	generate
		if (SW <= 11) begin : g_set_trunc
			assign req_set = req.set_index[SW-1:0];
		end else begin : g_set_ext
			assign req_set = {{(SW-11){1'b0}}, req.set_index};
		end
	endgenerate

	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign stall      = (op_q == OP_VICTIM) && out_valid_q && !rsp.ready;
	assign leave      = (state_q == ST_EXEC) && !stall;
	assign upd        = (op_q == OP_UPDATE) && ({1'b0, way_q} < 5'(NUM_WAYS));
	assign srrip_lead = ({1'b0, set_q} < LEAD_HALF);
	assign brrip_lead = !srrip_lead && ({1'b0, set_q} < LEAD_ALL);
	assign wrap       = (cnt_q == CW'(BLOCKS - 1));
	assign lfsr_nx    = lfsr_next(lfsr_q);

	assign ctl.op      = op_q;
	assign ctl.hit     = hit_q;
	assign ctl.srrip   = srrip_lead || (!brrip_lead && psel_q >= PSEL_MID);
	assign ctl.far_ins = (lfsr_nx[4:0] == 5'd0);

	assign rrpv_rd = rdata[RW-1:2*NUM_WAYS];
	assign dead_rd = rdata[2*NUM_WAYS-1:0];

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			dead_dec[w] = (dead_rd[w] != 2'd0) ? dead_rd[w] - 2'd1 : 2'd0;
		end
	end

	drrip_set_logic #(.NUM_WAYS(NUM_WAYS)) u_set (
		.ctl        (ctl),
		.valid_mask (vmask_q),
		.way        (way_q),
		.rrpv       (rrpv_rd),
		.dead       (dead_rd),
		.rrpv_new   (rrpv_new),
		.dead_new   (dead_new),
		.victim     (victim)
	);

	always_comb begin
		we    = 1'b0;
		waddr = set_q;
		wdata = {rrpv_new, dead_new};
		raddr = set_q;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = {{NUM_WAYS{RRPV_INS}}, {NUM_WAYS{DEAD_FILL}}};
			end
			ST_IDLE: begin
				raddr = req_set;
			end
			ST_EXEC: begin
				we = leave;
			end
			ST_DECAY_RD: begin
				raddr = sweep_q;
			end
			ST_DECAY_WR: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = {rrpv_rd, dead_dec};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	drrip_row_mem #(.DEPTH(NUM_SETS), .WIDTH(RW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			set_q   <= req_set;
			vmask_q <= req.valid_mask;
			way_q   <= req.way;
			hit_q   <= req.hit;
		end
		if (leave && op_q == OP_VICTIM) begin
			victim_q <= victim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sweep_q     <= '0;
			cnt_q       <= '0;
			psel_q      <= PSEL_MID;
			lfsr_q      <= LFSR_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (leave && op_q == OP_VICTIM) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + SW'(1);
					if (sweep_q == SW'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (leave) begin
						state_q <= ST_IDLE;
						if (upd) begin
							if (!hit_q && !ctl.srrip) begin
								lfsr_q <= lfsr_nx;
							end
							if (srrip_lead) begin
								if (hit_q && psel_q != PSEL_MAX) begin
									psel_q <= psel_q + 10'd1;
								end else if (!hit_q && psel_q != 10'd0) begin
									psel_q <= psel_q - 10'd1;
								end
							end else if (brrip_lead) begin
								if (!hit_q && psel_q != PSEL_MAX) begin
									psel_q <= psel_q + 10'd1;
								end else if (hit_q && psel_q != 10'd0) begin
									psel_q <= psel_q - 10'd1;
								end
							end
							cnt_q <= wrap ? '0 : cnt_q + CW'(1);
							if (wrap) begin
								sweep_q <= '0;
								state_q <= ST_DECAY_RD;
							end
						end
					end
				end
				ST_DECAY_RD: begin
					state_q <= ST_DECAY_WR;
				end
				ST_DECAY_WR: begin
					sweep_q <= sweep_q + SW'(1);
					state_q <= (sweep_q == SW'(NUM_SETS - 1)) ? ST_IDLE : ST_DECAY_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.victim_way = victim_q;

	`include "drrip_dead_block_replacement_assert.svh"

	`DRRIP_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC)
	`DRRIP_ASSERT_NEXT(a_wrap_decay, leave && upd && wrap, state_q == ST_DECAY_RD)
	`DRRIP_ASSERT_NOW(a_victim_range, out_valid_q, {1'b0, victim_q} < 5'(NUM_WAYS) || NUM_WAYS > 16)
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for drrip_dead_block_replacement: a clocked driver and monitor
// around a DRRIP dead-block predictor. Depends on drrip_pkg, drrip_if and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import drrip_pkg::*;

	localparam int SETS      = DEF_NUM_SETS;
	localparam int WAYS      = DEF_NUM_WAYS;
	localparam int LEADERS   = DEF_LEADER_SETS;
	localparam int BLOCKS    = SETS * WAYS;
	localparam int LIMIT     = 3000000;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic        op;
		logic [10:0] set_index;
		logic [15:0] valid_mask;
		logic [3:0]  way;
		logic        hit;
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	drrip_req_if req_ch ();
	drrip_rsp_if rsp_ch ();

	drrip_dead_block_replacement uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	access_t     access_q[$];
	logic [3:0]  victim_q[$];
	logic [1:0]  rrpv_mem[BLOCKS];
	logic [1:0]  dead_mem[BLOCKS];
	logic [9:0]  psel;
	logic [14:0] upd_cnt;
	logic [15:0] lfsr;
	int          errors = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;
	bit          hold_go = 1'b0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          hold_cnt = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [3:0] pick_victim(input logic [10:0] set, input logic [15:0] mask);
		int base;
		logic [1:0] top;
		base = int'(set) * WAYS;
		top = 2'd0;
		for (int w = 0; w < WAYS; w++)
			if (!mask[w])
				return w[3:0];
		for (int w = 0; w < WAYS; w++)
			if (dead_mem[base + w] == DEAD_MAX)
				return w[3:0];
		for (int w = 0; w < WAYS; w++)
			if (rrpv_mem[base + w] > top)
				top = rrpv_mem[base + w];
		for (int w = 0; w < WAYS; w++)
			rrpv_mem[base + w] = rrpv_mem[base + w] + (RRPV_MAX - top);
		for (int w = 0; w < WAYS; w++)
			if (rrpv_mem[base + w] == RRPV_MAX)
				return w[3:0];
		return 4'd0;
	endfunction

	function automatic void apply_access(input logic [10:0] set, input logic [3:0] way,
			input logic hit);
		int idx;
		bit srrip_leader;
		bit brrip_leader;
		bit near_ins;
		idx = int'(set) * WAYS + int'(way);
		srrip_leader = set < LEADERS / 2;
		brrip_leader = !srrip_leader && set < LEADERS;
		if (hit) begin
			if (dead_mem[idx] != 2'd0)
				dead_mem[idx] = dead_mem[idx] - 2'd1;
			rrpv_mem[idx] = RRPV_NEAR;
		end else begin
			near_ins = srrip_leader || (!brrip_leader && psel >= PSEL_MID);
			if (near_ins) begin
				rrpv_mem[idx] = RRPV_INS;
			end else begin
				lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
				rrpv_mem[idx] = (lfsr[4:0] == 5'd0) ? RRPV_MAX : RRPV_INS;
			end
			dead_mem[idx] = DEAD_FILL;
		end
		if (srrip_leader == hit && (srrip_leader || brrip_leader)) begin
			if (psel != PSEL_MAX)
				psel = psel + 10'd1;
		end else if (srrip_leader || brrip_leader) begin
			if (psel != 10'd0)
				psel = psel - 10'd1;
		end
		upd_cnt = upd_cnt + 15'd1;
		if (upd_cnt == 15'd0)
			for (int i = 0; i < BLOCKS; i++)
				if (dead_mem[i] != 2'd0)
					dead_mem[i] = dead_mem[i] - 2'd1;
	endfunction

	task automatic push_victim(input logic [10:0] set, input logic [15:0] mask);
		access_t a;
		a = '{op: OP_VICTIM, set_index: set, valid_mask: mask, way: 4'($urandom),
			hit: 1'($urandom)};
		access_q.push_back(a);
	endtask

	task automatic push_update(input logic [10:0] set, input logic [3:0] way, input logic hit);
		access_t a;
		a = '{op: OP_UPDATE, set_index: set, valid_mask: 16'($urandom), way: way, hit: hit};
		access_q.push_back(a);
	endtask

	task automatic drain();
		while (access_q.size() != 0 || req_ch.valid || victim_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [10:0] rand_set();
		case ($urandom_range(0, 3))
			0: return 11'($urandom_range(0, LEADERS / 2 - 1));
			1: return 11'($urandom_range(LEADERS / 2, LEADERS - 1));
			2: return 11'($urandom_range(LEADERS, LEADERS + 15));
			default: return 11'($urandom_range(0, SETS - 1));
		endcase
	endfunction

	function automatic logic [15:0] rand_mask();
		if ($urandom_range(0, 9) < 7)
			return 16'hFFFF;
		return 16'($urandom) | (16'($urandom) & 16'($urandom));
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		access_t a;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap = 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 10);
				req_ch.valid <= 1'b0;
			end else if (access_q.size() != 0) begin
				a = access_q.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.op         <= a.op;
				req_ch.set_index  <= a.set_index;
				req_ch.valid_mask <= a.valid_mask;
				req_ch.way        <= a.way;
				req_ch.hit        <= a.hit;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			rsp_ch.ready <= 1'b0;
		end else if (hold_go) begin
			hold_go = 1'b0;
			hold_cnt = LONG_HOLD - 1;
			rsp_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			rsp_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			recv_gap = $urandom_range(0, 10);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [3:0] want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (victim_q.size() == 0) begin
					$error("victim_way: unexpected transaction, actual %0d", rsp_ch.victim_way);
					errors++;
				end else begin
					want = victim_q.pop_front();
					if (rsp_ch.victim_way !== want) begin
						$error("victim_way: expected %0d, actual %0d", want, rsp_ch.victim_way);
						errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.op == OP_VICTIM)
					victim_q.push_back(pick_victim(req_ch.set_index, req_ch.valid_mask));
				else
					apply_access(req_ch.set_index, req_ch.way, req_ch.hit);
			end
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.op = OP_VICTIM;
		req_ch.set_index = '0;
		req_ch.valid_mask = '0;
		req_ch.way = '0;
		req_ch.hit = 1'b0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < BLOCKS; i++) begin
			rrpv_mem[i] = RRPV_INS;
			dead_mem[i] = DEAD_FILL;
		end
		psel = PSEL_MID;
		upd_cnt = '0;
		lfsr = LFSR_SEED;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		push_victim(11'd0, 16'h0000);
		push_victim(11'd2047, 16'hFFFE);
		push_victim(11'd1, 16'h7FFF);
		push_victim(11'd3, 16'hFFFF);
		for (int w = 0; w < WAYS; w++)
			push_update(11'd5, w[3:0], 1'b1);
		push_victim(11'd5, 16'hFFFF);
		push_update(11'd0, 4'd15, 1'b0);
		push_update(11'd40, 4'd7, 1'b0);
		push_update(11'd2047, 4'd9, 1'b0);
		push_update(11'd40, 4'd7, 1'b1);
		push_victim(11'd40, 16'hFFFF);
		drain();

		hold_go = 1'b1;
		for (int i = 0; i < 40; i++)
			push_victim(rand_set(), rand_mask());
		drain();

		for (int i = 0; i < 520; i++)
			push_update(11'($urandom_range(LEADERS / 2, LEADERS - 1)), 4'($urandom), 1'b0);
		for (int i = 0; i < 100; i++)
			if ($urandom_range(0, 1))
				push_victim(11'($urandom_range(LEADERS, LEADERS + 15)), rand_mask());
			else
				push_update(11'($urandom_range(LEADERS, LEADERS + 15)), 4'($urandom),
					1'($urandom));
		drain();

		for (int i = 0; i < 60; i++)
			if (i % 3 == 0)
				push_victim(rand_set(), rand_mask());
			else
				push_update(rand_set(), 4'($urandom), 1'($urandom));

		for (int i = 0; i < 850; i++) begin
			if (i == 700) begin
				drain();
				quiet = 1'b1;
			end
			if ($urandom_range(0, 9) < 4)
				push_victim(rand_set(), rand_mask());
			else
				push_update(rand_set(), 4'($urandom), 1'($urandom));
		end
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
